// ===== rtl/peak_hold_fall_tracker_assert.svh =====
// ----------------------------------------------------------------------------
// Peak hold fall tracker assertion macros
// Concurrent checks, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef PEAK_HOLD_FALL_TRACKER_ASSERT_SVH
`define PEAK_HOLD_FALL_TRACKER_ASSERT_SVH
`ifndef ASSERT_OFF
`define PHFT_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("property violated");
`define PHFT_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define PHFT_ASSERT(name, clk, rst, prop)
`define PHFT_NEVER(name, clk, rst, cond)
`endif
`endif

// ===== rtl/phft_pkg.sv =====
// ----------------------------------------------------------------------------
// Peak hold fall tracker package
// Shared widths, band state record, multiplier status and velocity clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package phft_pkg;
  localparam int BANDS  = 64;
  localparam int ADDR_W = $clog2(BANDS);
  localparam int VEL_W  = 24;
  localparam int MA_W   = 34;            // signed multiplicand
  localparam int MB_W   = 25;            // unsigned multiplier, one bit per cycle
  localparam int MP_W   = MA_W + MB_W + 1;
  localparam int MR_W   = MP_W - 16;     // rounded result
  localparam int CNT_W  = $clog2(MB_W + 1);
  localparam int EXT_W  = MR_W + 2;

  localparam logic [15:0] PEAK_DECAY = 16'd655;

  typedef struct packed {
    logic        [15:0] peak;
    logic        [23:0] hold;
    logic signed [23:0] vel;
    logic        [15:0] pos;
  } band_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_status_t;

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [EXT_W-1:0] x);
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    hi = EXT_W'(signed'(24'sh7FFFFF));
    lo = EXT_W'(signed'(24'sh800000));
    if (x > hi) return 24'sh7FFFFF;
    else if (x < lo) return 24'sh800000;
    else return x[VEL_W-1:0];
  endfunction
endpackage

// ===== rtl/phft_mul.sv =====
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Signed by unsigned shift-add, one multiplier bit per cycle, then a rounding
// step that drops 16 fraction bits, ties toward plus infinity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module phft_mul (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [phft_pkg::MA_W-1:0]  a,
  input  logic        [phft_pkg::MB_W-1:0]  b,
  output phft_pkg::mul_status_t             status,
  output logic signed [phft_pkg::MR_W-1:0]  res
);
  import phft_pkg::*;

  logic                    run;
  logic                    rnd;
  logic                    done;
  logic [CNT_W-1:0]        cnt;
  logic signed [MP_W-1:0]  acc;
  logic signed [MP_W-1:0]  mcand;
  logic [MB_W-1:0]         mplier;
  logic signed [MP_W-1:0]  rounded;

  assign rounded = acc + MP_W'(32768);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      rnd  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MB_W - 1)) begin
          run <= 1'b0;
          rnd <= 1'b1;
        end
      end else if (rnd) begin
        rnd  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath: add the shifted multiplicand when the low multiplier bit is set
  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= MP_W'(a);
      mplier <= b;
    end else if (run) begin
      if (mplier[0]) acc <= acc + mcand;
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
    end else if (rnd) begin
      res <= rounded[MP_W-1:16];
    end
  end

  assign status.busy = run | rnd;
  assign status.done = done;
endmodule

// ===== rtl/phft_bank.sv =====
// ----------------------------------------------------------------------------
// Band state memory
// One word per band, registered read; per-entry valid bits make an entry
// never written since reset read as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module phft_bank (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [phft_pkg::ADDR_W-1:0]   rd_addr,
  output phft_pkg::band_state_t         rd_data,
  input  logic                          wr_en,
  input  logic [phft_pkg::ADDR_W-1:0]   wr_addr,
  input  phft_pkg::band_state_t         wr_data
);
  import phft_pkg::*;

  band_state_t      mem [BANDS];
  logic [BANDS-1:0] valid;
  band_state_t      raw;
  logic             raw_vld;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) raw <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      raw_vld <= 1'b0;
    end else begin
      if (wr_en) valid[wr_addr] <= 1'b1;
      if (rd_en) raw_vld <= valid[rd_addr];
    end
  end

  assign rd_data = raw_vld ? raw : '0;
endmodule

// ===== rtl/peak_hold_fall_tracker.sv =====
// ----------------------------------------------------------------------------
// Peak hold fall tracker
// Per-band peak marker with hold, gravity or spring motion and edge handling.
// ----------------------------------------------------------------------------
// One item updates one band and returns one result item. The block works on
// one item at a time: read the band state, then, once the hold has run out,
// a chain of bit-serial multiplies on a single shared multiplier: 4 in
// gravity or spring mode, plus 1 when the marker bounces off an edge. A
// finished result sits in the output register, so the next item is taken
// while it waits. The band state lives in a 64-entry memory whose entries
// read as zero until written after reset; no clearing pass is needed.
`timescale 1ns / 1ps
`include "peak_hold_fall_tracker_assert.svh"
module peak_hold_fall_tracker (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [5:0] band_index, [21:6] band_level, [37:22] time_step
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [5:0] band_out, [21:6] marker_position
  output logic [1:0]  m_tuser    // [0] holding, [1] new_peak
);
  import phft_pkg::*;

  // register indexes
  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_GRAVITY = 3'd1;
  localparam logic [2:0] REG_HOLD    = 3'd2;
  localparam logic [2:0] REG_FALLOFF = 3'd3;
  localparam logic [2:0] REG_STIFF   = 3'd4;
  localparam logic [2:0] REG_DAMP    = 3'd5;
  localparam logic [2:0] REG_ELAST   = 3'd6;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_BOUND = 3'd4;
  localparam logic [2:0] ST_WRITE = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  // multiply steps
  localparam logic [2:0] OP_GRAV   = 3'd0;  // g * dt
  localparam logic [2:0] OP_FDT    = 3'd1;  // falloff * dt
  localparam logic [2:0] OP_FALL   = 3'd2;  // v * fd
  localparam logic [2:0] OP_SPRING = 3'd3;  // k * (level - p)
  localparam logic [2:0] OP_DAMP   = 3'd4;  // damping * v
  localparam logic [2:0] OP_ACCEL  = 3'd5;  // a * dt
  localparam logic [2:0] OP_MOVE   = 3'd6;  // v * dt
  localparam logic [2:0] OP_BOUNCE = 3'd7;  // v * elasticity

  // configuration
  logic [3:0]         mode_flags;
  logic signed [23:0] gravity_accel;
  logic [23:0]        hold_time;
  logic [23:0]        falloff_rate;
  logic [23:0]        spring_stiffness;
  logic [23:0]        spring_damping;
  logic [15:0]        bounce_elasticity;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_flags        <= 4'd1;
      gravity_accel     <= '0;
      hold_time         <= '0;
      falloff_rate      <= '0;
      spring_stiffness  <= '0;
      spring_damping    <= '0;
      bounce_elasticity <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MODE:    mode_flags        <= cfg_wdata[3:0];
        REG_GRAVITY: gravity_accel     <= cfg_wdata;
        REG_HOLD:    hold_time         <= cfg_wdata;
        REG_FALLOFF: falloff_rate      <= cfg_wdata;
        REG_STIFF:   spring_stiffness  <= cfg_wdata;
        REG_DAMP:    spring_damping    <= cfg_wdata;
        REG_ELAST:   bounce_elasticity <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // control and working registers
  logic [2:0]          state;
  logic [2:0]          step;
  logic                mul_start;
  logic [5:0]          band;
  logic [15:0]         level;
  logic [15:0]         dt;
  logic signed [25:0]  p;
  logic signed [23:0]  v;
  logic [23:0]         hold;
  logic [15:0]         peak;
  logic [24:0]         fd;
  logic signed [MA_W-1:0] acc_a;
  logic                np;

  band_state_t            rd_data;
  band_state_t            wr_data;
  mul_status_t            mul_st;
  logic signed [MA_W-1:0] mul_a;
  logic [MB_W-1:0]        mul_b;
  logic signed [MR_W-1:0] mul_res;

  logic                accept;
  logic signed [24:0]  g_eff;
  logic signed [EXT_W-1:0] t_ext;
  logic signed [EXT_W-1:0] v_ext;
  logic signed [EXT_W-1:0] a_ext;
  logic signed [EXT_W-1:0] g_ext;
  logic                ld_np;
  logic [23:0]         ld_hold;
  logic [15:0]         ld_pos;
  logic signed [23:0]  ld_vel;
  logic [16:0]         ld_decay;
  logic [15:0]         ld_peak;
  logic signed [16:0]  diff;
  logic                out_low;
  logic                out_high;

  assign accept   = s_tvalid & s_tready;
  assign s_tready = (state == ST_IDLE);

  // top-down flips gravity
  assign g_eff = mode_flags[3] ? -25'(gravity_accel) : 25'(gravity_accel);

  assign t_ext = EXT_W'(mul_res);
  assign v_ext = EXT_W'(v);
  assign a_ext = EXT_W'(acc_a);
  assign g_ext = EXT_W'(g_eff);

  // fresh peak snaps the marker; peak value decays by 0.01 but not below level
  always_comb begin
    ld_np    = (level > rd_data.peak);
    ld_hold  = ld_np ? hold_time : rd_data.hold;
    ld_pos   = ld_np ? level : rd_data.pos;
    ld_vel   = ld_np ? '0 : rd_data.vel;
    ld_decay = {1'b0, rd_data.peak} - {1'b0, PEAK_DECAY};
    if (ld_decay[16] || ld_decay[15:0] < level) ld_peak = level;
    else ld_peak = ld_decay[15:0];
  end

  assign diff     = signed'({1'b0, level}) - signed'({1'b0, p[15:0]});
  assign out_low  = p[25];
  assign out_high = !p[25] && (p > 26'sd65535);

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step)
      OP_GRAV:   begin mul_a = MA_W'(g_eff);                mul_b = MB_W'(dt); end
      OP_FDT:    begin mul_a = MA_W'({1'b0, falloff_rate}); mul_b = MB_W'(dt); end
      OP_FALL:   begin mul_a = MA_W'(v);                    mul_b = fd; end
      OP_SPRING: begin mul_a = MA_W'(diff);                 mul_b = MB_W'(spring_stiffness); end
      OP_DAMP:   begin mul_a = MA_W'(v);                    mul_b = MB_W'(spring_damping); end
      OP_ACCEL:  begin mul_a = acc_a;                       mul_b = MB_W'(dt); end
      OP_MOVE:   begin mul_a = MA_W'(v);                    mul_b = MB_W'(dt); end
      default:   begin mul_a = MA_W'(v);                    mul_b = MB_W'(bounce_elasticity); end
    endcase
  end

  phft_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .status (mul_st),
    .res    (mul_res)
  );

  assign wr_data.peak = peak;
  assign wr_data.hold = hold;
  assign wr_data.vel  = v;
  assign wr_data.pos  = p[15:0];

  phft_bank u_bank (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (s_tdata[ADDR_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (state == ST_WRITE),
    .wr_addr (band[ADDR_W-1:0]),
    .wr_data (wr_data)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= OP_GRAV;
      mul_start <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      // drop valid once taken, unless a new result lands in the same cycle
      if (m_tvalid && m_tready && state != ST_OUT) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) state <= ST_READ;
        end
        ST_READ: state <= ST_LOAD;
        ST_LOAD: begin
          if (!mode_flags[0]) begin
            state <= ST_OUT;
          end else if (ld_hold != '0) begin
            state <= ST_WRITE;
          end else begin
            step      <= mode_flags[1] ? OP_SPRING : OP_GRAV;
            mul_start <= 1'b1;
            state     <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_st.done) begin
            mul_start <= 1'b1;
            case (step)
              OP_GRAV:   step <= OP_FDT;
              OP_FDT:    step <= OP_FALL;
              OP_FALL:   step <= OP_MOVE;
              OP_SPRING: step <= OP_DAMP;
              OP_DAMP:   step <= OP_ACCEL;
              OP_ACCEL:  step <= OP_MOVE;
              OP_MOVE: begin
                mul_start <= 1'b0;
                state     <= ST_BOUND;
              end
              default: begin
                mul_start <= 1'b0;
                state     <= ST_WRITE;
              end
            endcase
          end
        end
        ST_BOUND: begin
          if ((out_low || out_high) && !mode_flags[2]) begin
            step      <= OP_BOUNCE;
            mul_start <= 1'b1;
            state     <= ST_MUL;
          end else begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: state <= ST_OUT;
        ST_OUT: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // working datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      band  <= s_tdata[5:0];
      level <= s_tdata[21:6];
      dt    <= s_tdata[37:22];
    end
    if (state == ST_LOAD) begin
      if (!mode_flags[0]) begin
        p    <= 26'(rd_data.pos);
        hold <= rd_data.hold;
        np   <= 1'b0;
      end else begin
        np   <= ld_np;
        p    <= 26'(ld_pos);
        v    <= ld_vel;
        peak <= ld_peak;
        // drop the hold by the time step, stop at zero
        if (ld_hold > 24'(dt)) hold <= ld_hold - 24'(dt);
        else hold <= '0;
      end
    end
    if (state == ST_MUL && mul_st.done) begin
      case (step)
        OP_GRAV:   v     <= sat_vel(v_ext - t_ext);
        OP_FDT:    fd    <= mul_res[24:0];
        OP_FALL:   v     <= sat_vel(v_ext - t_ext);
        OP_SPRING: acc_a <= MA_W'(t_ext - g_ext);
        OP_DAMP:   acc_a <= MA_W'(a_ext - t_ext);
        OP_ACCEL:  v     <= sat_vel(v_ext + t_ext);
        OP_MOVE:   p     <= p + 26'(mul_res);
        default:   v     <= sat_vel(-t_ext);
      endcase
    end
    if (state == ST_BOUND) begin
      if (out_low || out_high) begin
        if (mode_flags[2]) begin
          // respawn at the level and restart the hold
          p    <= 26'(level);
          v    <= '0;
          hold <= hold_time;
        end else if (out_low) begin
          p <= '0;
        end else begin
          p <= 26'sd65535;
        end
      end
    end
    if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {2'b00, p[15:0], band};
      m_tuser <= {np, (hold != '0)};
    end
  end

  `PHFT_ASSERT(a_accept_reads, clk, rst, accept |=> state == ST_READ)
  `PHFT_NEVER(a_start_busy, clk, rst, mul_start && mul_st.busy)
  `PHFT_ASSERT(a_done_in_mul, clk, rst, mul_st.done |-> state == ST_MUL)
endmodule

// ===== bench/phft_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// Peak hold fall tracker bench package
// Register indexes and mode bits shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package phft_tb_pkg;
  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_GRAVITY = 3'd1;
  localparam logic [2:0] REG_HOLD    = 3'd2;
  localparam logic [2:0] REG_FALLOFF = 3'd3;
  localparam logic [2:0] REG_STIFF   = 3'd4;
  localparam logic [2:0] REG_DAMP    = 3'd5;
  localparam logic [2:0] REG_ELAST   = 3'd6;

  localparam int MODE_ENABLE   = 0;
  localparam int MODE_SPRING   = 1;
  localparam int MODE_RESPAWN  = 2;
  localparam int MODE_TOP_DOWN = 3;
endpackage

// ===== bench/phft_checker.sv =====
// ----------------------------------------------------------------------------
// Peak hold fall tracker checker
// Tracks register writes, predicts each band update and compares results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module phft_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic [1:0]  m_tuser,
  output int          fail_count,
  output int          pending,
  output int          checked
);
  import phft_tb_pkg::*;

  typedef struct packed {
    logic [5:0]  band;
    logic [15:0] pos;
    logic        holding;
    logic        new_peak;
  } marker_result_t;

  localparam longint VMAX = 64'sd8388607;
  localparam longint VMIN = -64'sd8388608;

  logic [3:0]         mode_r;
  logic signed [23:0] grav_r;
  logic [23:0]        hold_r, falloff_r, stiff_r, damp_r;
  logic [15:0]        elast_r;

  logic [15:0]        pos_mem  [64];
  logic signed [23:0] vel_mem  [64];
  logic [23:0]        hold_mem [64];
  logic [15:0]        peak_mem [64];

  marker_result_t marker_q[$];

  // Q.16 product, rounded to nearest with ties upward
  function automatic longint qmul(longint a, longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  task automatic update_band(input logic [39:0] d, output marker_result_t r);
    int     b;
    longint lvl, dt, p, v, g, a, fd, pk;
    b   = d[5:0];
    lvl = d[21:6];
    dt  = d[37:22];
    r   = '0;
    r.band = d[5:0];
    if (mode_r[MODE_ENABLE]) begin
      if (lvl > longint'(peak_mem[b])) begin
        r.new_peak  = 1'b1;
        pos_mem[b]  = d[21:6];
        vel_mem[b]  = '0;
        hold_mem[b] = hold_r;
      end
      if (hold_mem[b] != 0) begin
        // hold still running: count down, no motion
        hold_mem[b] = (longint'(hold_mem[b]) > dt) ? hold_mem[b] - 24'(dt) : 24'd0;
      end else begin
        g = mode_r[MODE_TOP_DOWN] ? -longint'(grav_r) : longint'(grav_r);
        p = pos_mem[b];
        v = vel_mem[b];
        if (mode_r[MODE_SPRING]) begin
          a = qmul(longint'(stiff_r), lvl - p) - qmul(longint'(damp_r), v) - g;
          v = clip(v + qmul(a, dt), VMIN, VMAX);
        end else begin
          fd = qmul(longint'(falloff_r), dt);
          v  = clip(v - qmul(g, dt), VMIN, VMAX);
          v  = clip(v - qmul(v, fd), VMIN, VMAX);
        end
        p = p + qmul(v, dt);
        if (p < 0 || p > 65535) begin
          if (mode_r[MODE_RESPAWN]) begin
            p = lvl;
            v = 0;
            hold_mem[b] = hold_r;
          end else begin
            p = clip(p, 0, 65535);
            v = clip(-qmul(v, longint'(elast_r)), VMIN, VMAX);
          end
        end
        pos_mem[b] = p[15:0];
        vel_mem[b] = v[23:0];
      end
      pk = longint'(peak_mem[b]) - 655;
      if (pk < lvl) pk = lvl;
      peak_mem[b] = pk[15:0];
    end
    r.pos     = pos_mem[b];
    r.holding = hold_mem[b] != 0;
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    marker_result_t r, e;
    if (rst) begin
      mode_r = 4'd1;
      grav_r = '0;
      hold_r = '0;
      falloff_r = '0;
      stiff_r = '0;
      damp_r = '0;
      elast_r = '0;
      for (int i = 0; i < 64; i++) begin
        pos_mem[i] = '0;
        vel_mem[i] = '0;
        hold_mem[i] = '0;
        peak_mem[i] = '0;
      end
      marker_q.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_MODE:    mode_r = cfg_wdata[3:0];
          REG_GRAVITY: grav_r = cfg_wdata;
          REG_HOLD:    hold_r = cfg_wdata;
          REG_FALLOFF: falloff_r = cfg_wdata;
          REG_STIFF:   stiff_r = cfg_wdata;
          REG_DAMP:    damp_r = cfg_wdata;
          REG_ELAST:   elast_r = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        update_band(s_tdata, r);
        marker_q = {marker_q, r};
      end
      if (m_tvalid && m_tready) begin
        checked++;
        if (marker_q.size() == 0) begin
          report("unexpected result, band", m_tdata[5:0], -1);
        end else begin
          e = marker_q.pop_front();
          if (m_tdata[5:0] != e.band) report("band_out", m_tdata[5:0], e.band);
          if (m_tdata[21:6] != e.pos) report("marker_position", m_tdata[21:6], e.pos);
          if (m_tuser[0] != e.holding) report("holding", m_tuser[0], e.holding);
          if (m_tuser[1] != e.new_peak) report("new_peak", m_tuser[1], e.new_peak);
        end
      end
    end
    pending = marker_q.size();
  end
endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Peak hold fall tracker testbench
// Drives band items through a series of register settings with random idling
// on both sides; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import phft_tb_pkg::*;

  localparam int PHASES      = 8;
  localparam int RAND_ITEMS  = 130;       // random items per register setting
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN       = 200;       // beyond the longest bounce update

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // [5:0] band_index, [21:6] band_level, [37:22] time_step
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // [5:0] band_out, [21:6] marker_position
  logic [1:0]  m_tuser;   // [0] holding, [1] new_peak

  int  fail_count, pending, checked, sent, cycles;
  bit  quiet;             // no idling on either side
  bit  long_stall;        // ask the receiver for one long hold-off

  // register settings per phase: mode, gravity, hold, falloff, stiffness,
  // damping, elasticity
  logic [23:0] settings [PHASES][7] = '{
    '{24'h1, 24'h020000, 24'd3000,   24'h008000, 24'h0,      24'h0,      24'h8000},
    '{24'h5, 24'h7FFFFF, 24'd0,      24'hFFFFFF, 24'h0,      24'h0,      24'hFFFF},
    '{24'h3, 24'h010000, 24'd2000,   24'h0,      24'h0A0000, 24'h020000, 24'hC000},
    '{24'hB, 24'h800000, 24'd0,      24'h0,      24'hFFFFFF, 24'hFFFFFF, 24'h4000},
    '{24'h9, 24'h030000, 24'd500,    24'h010000, 24'h0,      24'h0,      24'h0},
    '{24'h0, 24'h040000, 24'd100,    24'h0,      24'h0,      24'h0,      24'h0},
    '{24'hD, 24'hFB0000, 24'hFFFFFF, 24'h0,      24'h0,      24'h0,      24'h0},
    '{24'h1, 24'h0,      24'd0,      24'h0,      24'h0,      24'h0,      24'h0}
  };

  peak_hold_fall_tracker u_top (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  phft_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: end a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[peak_hold_fall_tracker] ERROR");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    bit stall_done;
    stall_done = 1'b0;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_stall && !stall_done) begin
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
        stall_done = 1'b1;
        m_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // offer one item and hold it until taken, then maybe idle a burst
  task automatic send_item(input logic [5:0] band, input logic [15:0] lvl,
                           input logic [15:0] dt);
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, dt, lvl, band};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // drop valid and wait until every result is back and the block is idle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // write all registers of one setting, one per cycle
  task automatic load_setting(input int ph);
    for (int i = 0; i < 7; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= settings[ph][i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [5:0]  band;
    logic [15:0] lvl, dt;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = REG_MODE;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    quiet = 1'b0;
    long_stall = 1'b0;
    sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings first: field extremes and new peaks with zero hold and gravity
    send_item(6'd0,  16'hFFFF, 16'd0);
    send_item(6'd63, 16'd0,    16'hFFFF);
    send_item(6'd0,  16'd0,    16'hFFFF);
    send_item(6'd63, 16'h8000, 16'd1);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      load_setting(ph);
      quiet = (ph == PHASES - 1);
      // directed per setting: peak snap, running hold, release and edge hits
      send_item(6'd1, 16'hFFFF, 16'd10);
      send_item(6'd1, 16'd0,    16'd100);
      send_item(6'd1, 16'd0,    16'hFFFF);
      send_item(6'd1, 16'd0,    16'hFFFF);
      send_item(6'd1, 16'd20,   16'd0);
      for (int n = 0; n < RAND_ITEMS; n++) begin
        if (ph == 2 && n == 40) long_stall = 1'b1;
        if (ph == 4 && n == 60) drain_results();
        // most updates hit a few bands so markers get to move repeatedly
        band = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 7))
                                           : 6'($urandom_range(0, 63));
        case ($urandom_range(0, 3))
          0:       lvl = 16'd0;
          1:       lvl = 16'($urandom_range(0, 2000));
          default: lvl = 16'($urandom_range(0, 65535));
        endcase
        dt = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 4000))
                                         : 16'($urandom_range(0, 65535));
        send_item(band, lvl, dt);
      end
    end

    drain_results();
    $display("run covered %0d items over %0d register settings, %0d results checked",
             sent, PHASES + 1, checked);
    $display("settings spanned gravity, spring, top-down, respawn, bounce and disabled");
    if (fail_count == 0) begin
      $display("[peak_hold_fall_tracker] OK");
    end else begin
      $display("[peak_hold_fall_tracker] ERROR");
    end
    $finish;
  end
endmodule
